@@ rtl/sda_pkg.sv @@
// Shared types, character codes and sizing helpers for the scaled decimal to ASCII block.
// No dependencies; imported by every module of the block.
package sda_pkg;

	localparam int MAG_BITS_DEF  = 128;
	localparam int MAX_SCALE_DEF = 38;
	localparam int SCALE_W       = 6;
	localparam int CHAR_W        = 6;

	// ASCII codes, low six bits
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT,
		ST_POINT
	} sda_state_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic load;
		logic step;
	} sda_ctrl_t;

	// Datapath to sequencer status
	typedef struct packed {
		logic [3:0] digit;
		logic       nonzero;
	} sda_stat_t;

	// Decimal digits held: enough for 2^bits-1 and for a zero before a full scale
	function automatic int sda_bcd_digits(input int mag_bits, input int max_scale);
		int n;
		n = (mag_bits * 30103) / 100000 + 1;
		return (n > max_scale + 1) ? n : max_scale + 1;
	endfunction

endpackage

@@ rtl/scaled_decimal_to_ascii.sv @@
// Top level of the scaled decimal to ASCII converter.
// Depends on sda_pkg, sda_dabble and sda_seq.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | magnitude_low, magnitude_high, scale, is_positive
//  out     | output    | out_valid / out_ready| text_char, last_char
//
// One number is taken in one transfer and converted by shift-and-add-3 in the per-digit
// adjust logic; leading zero digits are then skipped and the sign, digits and point emitted.
// in_ready is high only while the sequencer is idle; a stalled character holds in the
// output register and stops the sequencer. Reset clears the sequencer and output valid.
module scaled_decimal_to_ascii #(
	parameter int MAG_BITS  = sda_pkg::MAG_BITS_DEF,
	parameter int MAX_SCALE = sda_pkg::MAX_SCALE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [63:0]                    magnitude_low,
	input  logic [63:0]                    magnitude_high,
	input  logic [sda_pkg::SCALE_W-1:0]    scale,
	input  logic                           is_positive,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sda_pkg::CHAR_W-1:0]     text_char,
	output logic                           last_char
);
	import sda_pkg::*;

	localparam int NBCD  = sda_bcd_digits(MAG_BITS, MAX_SCALE);
	localparam int PTR_W = $clog2(NBCD);

	sda_ctrl_t         ctrl;
	sda_stat_t         stat;
	logic [PTR_W-1:0]  ptr;

	sda_dabble #(
		.MAG_BITS (MAG_BITS),
		.MAX_SCALE(MAX_SCALE),
		.PTR_W    (PTR_W)
	) u_dabble (
		.clk           (clk),
		.ctrl          (ctrl),
		.magnitude_low (magnitude_low),
		.magnitude_high(magnitude_high),
		.ptr           (ptr),
		.stat          (stat)
	);

	sda_seq #(
		.MAG_BITS (MAG_BITS),
		.MAX_SCALE(MAX_SCALE),
		.PTR_W    (PTR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scale      (scale),
		.is_positive(is_positive),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.text_char  (text_char),
		.last_char  (last_char),
		.ctrl       (ctrl),
		.ptr        (ptr),
		.stat       (stat)
	);

endmodule

@@ rtl/sda_dabble.sv @@
// Shift-and-add-3 binary to BCD converter with a digit read port.
// Depends on sda_pkg for the control and status structs and the digit count.
module sda_dabble #(
	parameter int MAG_BITS  = sda_pkg::MAG_BITS_DEF,
	parameter int MAX_SCALE = sda_pkg::MAX_SCALE_DEF,
	parameter int PTR_W     = 6
) (
	input  logic                 clk,
	input  sda_pkg::sda_ctrl_t   ctrl,
	input  logic [63:0]          magnitude_low,
	input  logic [63:0]          magnitude_high,
	input  logic [PTR_W-1:0]     ptr,
	output sda_pkg::sda_stat_t   stat
);
	import sda_pkg::*;

	localparam int NBCD = sda_bcd_digits(MAG_BITS, MAX_SCALE);

	logic [127:0]              mag_full;
	logic [MAG_BITS-1:0]       mag_in;
	logic [MAG_BITS-1:0]       bin_q;
	logic [NBCD-1:0][3:0]      bcd_q;
	logic [NBCD-1:0][3:0]      adj;
	logic [4*NBCD-1:0]         adj_flat;

	assign mag_full = {magnitude_high, magnitude_low};
	assign mag_in   = mag_full[MAG_BITS-1:0];

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NBCD; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end
	assign adj_flat = adj;

	// Load the magnitude, or shift one bit from the binary word into the digits
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag_in;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[MAG_BITS-2:0], 1'b0};
			bcd_q <= {adj_flat[4*NBCD-2:0], bin_q[MAG_BITS-1]};
		end
	end

	assign stat.digit   = bcd_q[ptr];
	assign stat.nonzero = |mag_in;

endmodule

@@ rtl/sda_seq.sv @@
// Sequencer: conversion bit count, leading zero skip, character emission and output register.
// Depends on sda_pkg for states, character codes and the control and status structs.
module sda_seq #(
	parameter int MAG_BITS  = sda_pkg::MAG_BITS_DEF,
	parameter int MAX_SCALE = sda_pkg::MAX_SCALE_DEF,
	parameter int PTR_W     = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sda_pkg::SCALE_W-1:0]    scale,
	input  logic                           is_positive,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sda_pkg::CHAR_W-1:0]     text_char,
	output logic                           last_char,
	output sda_pkg::sda_ctrl_t             ctrl,
	output logic [PTR_W-1:0]               ptr,
	input  sda_pkg::sda_stat_t             stat
);
	import sda_pkg::*;

	localparam int NBCD  = sda_bcd_digits(MAG_BITS, MAX_SCALE);
	localparam int CNT_W = $clog2(MAG_BITS);
	localparam int CMP_W = (PTR_W > SCALE_W) ? PTR_W : SCALE_W;

	sda_state_t          state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [SCALE_W-1:0]  scale_sat;
	logic                neg_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                accept;
	logic                slot_free;
	logic                conv_done;
	logic                skip_more;
	logic                at_point;
	logic                emit;
	logic [CHAR_W-1:0]   emit_char;
	logic                emit_last;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign conv_done = (cnt_q == CNT_W'(MAG_BITS - 1));
	assign skip_more = (CMP_W'(ptr_q) > CMP_W'(scale_q)) && (stat.digit == 4'd0);
	assign at_point  = (CMP_W'(ptr_q) == CMP_W'(scale_q));
	assign scale_sat = (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CONV;
			ST_CONV:  if (conv_done) state_d = ST_SKIP;
			ST_SKIP:  if (!skip_more) state_d = neg_q ? ST_SIGN : ST_DIGIT;
			ST_SIGN:  if (slot_free) state_d = ST_DIGIT;
			ST_DIGIT: begin
				if (slot_free) begin
					if (ptr_q == '0) state_d = ST_IDLE;
					else if (at_point) state_d = ST_POINT;
				end
			end
			ST_POINT: if (slot_free) state_d = ST_DIGIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath controls and character selection
	always_comb begin
		in_ready  = 1'b0;
		ctrl.load = 1'b0;
		ctrl.step = 1'b0;
		emit      = 1'b0;
		emit_char = CHAR_ZERO;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			ST_CONV: ctrl.step = 1'b1;
			ST_SIGN: begin
				emit      = slot_free;
				emit_char = CHAR_MINUS;
			end
			ST_DIGIT: begin
				emit      = slot_free;
				emit_char = CHAR_ZERO + {2'b00, stat.digit};
				emit_last = (ptr_q == '0);
			end
			ST_POINT: begin
				emit      = slot_free;
				emit_char = CHAR_POINT;
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (state_q == ST_CONV) cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_CONV && conv_done) ptr_q <= PTR_W'(NBCD - 1);
			else if (state_q == ST_SKIP && skip_more) ptr_q <= ptr_q - PTR_W'(1);
			else if (state_q == ST_DIGIT && slot_free && ptr_q != '0)
				ptr_q <= ptr_q - PTR_W'(1);
		end
	end

	// Capture scale and sign on the input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			scale_q <= scale_sat;
			neg_q   <= !is_positive && stat.nonzero;
		end
	end

	// Output register: hold while stalled, refill when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;
	assign ptr       = ptr_q;

endmodule

@@ rtl/sda_checker.sv @@
// Port-level checks for the scaled decimal to ASCII converter, bound to the top level.
// Depends on sda_pkg for the character codes.
module sda_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sda_pkg::CHAR_W-1:0]     text_char,
	input logic                           last_char
);
	import sda_pkg::*;

	// Stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
		else $error("stalled character changed");

	// Busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after input transfer");

	// Text always ends on a digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (text_char == CHAR_MINUS || text_char == CHAR_POINT) |-> !last_char)
		else $error("text ends on sign or point");

	// Only sign, point or digit codes appear
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_char == CHAR_MINUS || text_char == CHAR_POINT
			|| (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 6'd9))
		else $error("bad character code");

endmodule

bind scaled_decimal_to_ascii sda_checker u_sda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.text_char(text_char),
	.last_char(last_char)
);

@@ bench/scaled_decimal_to_ascii_test.sv @@
// Self-checking bench for scaled_decimal_to_ascii: drives numbers, predicts their text and
// compares every character and last marker. Depends on sda_pkg and the block's RTL.
module scaled_decimal_to_ascii_test;

	import sda_pkg::*;

	localparam int MAG_BITS       = MAG_BITS_DEF;
	localparam int MAX_SCALE      = MAX_SCALE_DEF;
	localparam int IDLE_PCT       = 21;
	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 250;
	localparam int RANDOM_NUMBERS = 310;
	localparam int CALM_NUMBERS   = 80;

	localparam logic [127:0] TEN_POW_38 = 128'd100000000000000000000000000000000000000;
	localparam logic [127:0] ALL_ONES   = {128{1'b1}};

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} ascii_item_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [63:0]        magnitude_low;
	logic [63:0]        magnitude_high;
	logic [SCALE_W-1:0] scale;
	logic               is_positive;
	logic               out_valid;
	logic               out_ready;
	logic [CHAR_W-1:0]  text_char;
	logic               last_char;

	ascii_item_t pending_chars[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	logic        idle_on = 1'b1;

	scaled_decimal_to_ascii #(
		.MAG_BITS (MAG_BITS),
		.MAX_SCALE(MAX_SCALE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.magnitude_low (magnitude_low),
		.magnitude_high(magnitude_high),
		.scale         (scale),
		.is_positive   (is_positive),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.text_char     (text_char),
		.last_char     (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Append the expected text of one number to the pending characters
	function automatic void format_scaled_text(input logic [127:0] mag_in,
			input logic [SCALE_W-1:0] sc, input logic pos);
		logic [127:0]  mag;
		int            eff_scale;
		int            k;
		bit            nonzero;
		byte unsigned  digits[$];
		ascii_item_t   chars[$];
		ascii_item_t   item;
		mag = mag_in & (ALL_ONES >> (128 - MAG_BITS));
		eff_scale = (int'(sc) > MAX_SCALE) ? MAX_SCALE : int'(sc);
		nonzero = (mag != 0);
		// digits, least significant first
		if (!nonzero)
			digits.insert(digits.size(), 8'd0);
		while (mag != 0) begin
			digits.insert(digits.size(), byte'(mag % 10));
			mag = mag / 10;
		end
		// pad so that one digit stands before the point
		if (eff_scale > 0)
			while (digits.size() <= eff_scale)
				digits.insert(digits.size(), 8'd0);
		item.last = 1'b0;
		if (!pos && nonzero) begin
			item.code = CHAR_MINUS;
			chars.insert(chars.size(), item);
		end
		for (k = digits.size() - 1; k >= 0; k--) begin
			item.code = CHAR_ZERO + CHAR_W'(digits[k]);
			chars.insert(chars.size(), item);
			if (eff_scale > 0 && k == eff_scale) begin
				item.code = CHAR_POINT;
				chars.insert(chars.size(), item);
			end
		end
		chars[chars.size() - 1].last = 1'b1;
		for (k = 0; k < chars.size(); k++)
			pending_chars.insert(pending_chars.size(), chars[k]);
	endfunction

	// Offer one number, hold it until the transfer, then record its expected text
	task automatic send_number(input logic [127:0] mag, input logic [SCALE_W-1:0] sc,
			input logic pos);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(260, 1)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		magnitude_low  <= mag[63:0];
		magnitude_high <= mag[127:64];
		scale          <= sc;
		is_positive    <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		format_scaled_text(mag, sc, pos);
	endtask

	// Stall the character channel at random unless idling is off
	always @(posedge clk) begin
		out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
	end

	// Compare each character transfer with the oldest expectation
	always @(posedge clk) begin
		ascii_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected character: expected none actual %0d last %0b",
					$time, text_char, last_char);
			end else begin
				want = pending_chars.pop_front();
				if (text_char !== want.code) begin
					mismatch_count++;
					$display("%0t text_char mismatch: expected %0d actual %0d",
						$time, want.code, text_char);
				end
				if (last_char !== want.last) begin
					mismatch_count++;
					$display("%0t last_char mismatch: expected %0b actual %0b",
						$time, want.last, last_char);
				end
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t timeout: %0d characters still expected", $time, pending_chars.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_zero_values();
		send_number(128'd0, 6'd0, 1'b1);
		send_number(128'd0, 6'd0, 1'b0);
		send_number(128'd0, 6'd5, 1'b0);
		send_number(128'd0, 6'd38, 1'b1);
	endtask

	task automatic test_magnitude_extremes();
		send_number(ALL_ONES, 6'd0, 1'b1);
		send_number(ALL_ONES, 6'd38, 1'b0);
		send_number({64'd1, 64'd0}, 6'd0, 1'b0);
		send_number({64'd0, ALL_ONES[63:0]}, 6'd20, 1'b1);
		send_number(128'd9, 6'd0, 1'b0);
		send_number(128'd10, 6'd0, 1'b1);
	endtask

	task automatic test_point_placement();
		send_number(128'd1, 6'd1, 1'b1);
		send_number(128'd12345, 6'd2, 1'b0);
		send_number(128'd999, 6'd3, 1'b1);
		send_number(128'd1000, 6'd3, 1'b0);
		send_number(TEN_POW_38, 6'd38, 1'b0);
		send_number(TEN_POW_38 - 1, 6'd38, 1'b1);
		send_number(TEN_POW_38 - 1, 6'd37, 1'b0);
	endtask

	// Scales above the limit act as the limit
	task automatic test_scale_saturation();
		send_number(128'd7, 6'd39, 1'b0);
		send_number(TEN_POW_38, 6'd40, 1'b1);
		send_number(ALL_ONES, 6'd63, 1'b0);
		send_number(128'd0, 6'd63, 1'b0);
	endtask

	task automatic test_random_numbers();
		logic [127:0]       mag;
		logic [SCALE_W-1:0] sc;
		// start with a long stretch without idling on either side
		idle_on <= 1'b0;
		for (int n = 0; n < RANDOM_NUMBERS; n++) begin
			if (n == CALM_NUMBERS)
				idle_on <= 1'b1;
			case ($urandom_range(3))
				0: mag = 128'($urandom_range(999));
				1: mag = {$urandom, $urandom, $urandom, $urandom};
				default: mag = {$urandom, $urandom, $urandom, $urandom} >> $urandom_range(128);
			endcase
			case ($urandom_range(9))
				6, 7: sc = SCALE_W'($urandom_range(3));
				8: sc = SCALE_W'($urandom_range(63, 39));
				9: sc = SCALE_W'($urandom_range(63));
				default: sc = SCALE_W'($urandom_range(MAX_SCALE));
			endcase
			send_number(mag, sc, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		magnitude_low  <= '0;
		magnitude_high <= '0;
		scale          <= '0;
		is_positive    <= 1'b1;
		out_ready      <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_values();
		test_magnitude_extremes();
		test_point_placement();
		test_scale_saturation();
		test_random_numbers();

		// drain the remaining text, then watch for stray characters
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
